### design/asiq_pkg.sv
package asiq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // one stored process descriptor
  typedef struct packed {
    logic [15:0] process_id;
    logic [15:0] arr_time;
    logic [15:0] burst_length;
    logic [7:0]  prio_level;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_INS_OK = 2'd0,
    ST_POP_OK = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_HEAD_CMP,
    S_SCAN_CMP,
    S_POP,
    S_POP_DATA
  } state_t;

  typedef enum logic {
    RD_HEAD,
    RD_POS_M1
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_HEAD,
    WR_HEAD_M1,
    WR_POS
  } wr_sel_t;

  // sequencer -> datapath controls
  typedef struct packed {
    logic    load;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    wr_shift;   // write the entry just read instead of the new one
    logic    pos_init;
    logic    pos_dec;
    logic    head_dec;
    logic    head_inc;
    logic    cnt_inc;
    logic    cnt_dec;
  } ctl_t;

  // datapath -> sequencer flags
  typedef struct packed {
    logic empty;
    logic full;
    logic arr_le_rd;
    logic arr_lt_rd;
  } flags_t;

endpackage

### design/asiq_ram.sv
module asiq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### design/asiq_dpath.sv
module asiq_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  asiq_pkg::ctl_t                 ctl,
  input  logic [15:0]                    in_process_id,
  input  logic [15:0]                    in_arrival_time,
  input  logic [15:0]                    in_burst_length,
  input  logic [7:0]                     in_prio_level,
  output asiq_pkg::flags_t               flags,
  output logic [asiq_pkg::CNT_W-1:0]     count_nxt,
  output logic                           ram_wr_en,
  output logic [asiq_pkg::IDX_W-1:0]     ram_wr_addr,
  output logic [asiq_pkg::ENTRY_W-1:0]   ram_wr_data,
  output logic [asiq_pkg::IDX_W-1:0]     ram_rd_addr,
  input  logic [asiq_pkg::ENTRY_W-1:0]   ram_rd_data
);

  localparam int IW = asiq_pkg::IDX_W;
  localparam int CW = asiq_pkg::CNT_W;

  // circular buffer: logical slot -> physical address
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base, input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IW+1)'(asiq_pkg::QUEUE_DEPTH)) begin
      sum = sum - (IW+1)'(asiq_pkg::QUEUE_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  logic [IW-1:0]        head_r, head_nxt, head_m1;
  logic [CW-1:0]        count_r;
  logic [IW-1:0]        pos_r, pos_nxt;
  asiq_pkg::entry_t     item_r;
  asiq_pkg::entry_t     rd_entry;

  assign rd_entry = asiq_pkg::entry_t'(ram_rd_data);
  assign head_m1  = (head_r == '0) ? IW'(asiq_pkg::QUEUE_DEPTH - 1) : head_r - 1'b1;

  always_comb begin
    head_nxt = head_r;
    if (ctl.head_dec) begin
      head_nxt = head_m1;
    end else if (ctl.head_inc) begin
      head_nxt = phys(head_r, IW'(1));
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (ctl.pos_init) begin
      pos_nxt = count_r[IW-1:0];
    end else if (ctl.pos_dec) begin
      pos_nxt = pos_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (ctl.load) begin
      item_r.process_id   <= in_process_id;
      item_r.arr_time     <= in_arrival_time;
      item_r.burst_length <= in_burst_length;
      item_r.prio_level   <= in_prio_level;
    end
  end

  // read address follows the next slot position so a scan reads one ahead
  always_comb begin
    case (ctl.rd_sel)
      asiq_pkg::RD_HEAD:   ram_rd_addr = head_r;
      asiq_pkg::RD_POS_M1: ram_rd_addr = phys(head_r, pos_nxt - 1'b1);
      default:             ram_rd_addr = head_r;
    endcase
  end

  always_comb begin
    case (ctl.wr_sel)
      asiq_pkg::WR_HEAD:    ram_wr_addr = head_r;
      asiq_pkg::WR_HEAD_M1: ram_wr_addr = head_m1;
      asiq_pkg::WR_POS:     ram_wr_addr = phys(head_r, pos_r);
      default:              ram_wr_addr = head_r;
    endcase
  end

  assign ram_wr_en   = ctl.wr_en;
  assign ram_wr_data = ctl.wr_shift ? ram_rd_data : item_r;

  // fill flags and the two key comparators, both on the entry just read
  assign flags.empty     = (count_r == '0);
  assign flags.full      = (count_r == CW'(asiq_pkg::QUEUE_DEPTH));
  assign flags.arr_le_rd = (item_r.arr_time <= rd_entry.arr_time);
  assign flags.arr_lt_rd = (item_r.arr_time <  rd_entry.arr_time);

endmodule

### design/arrival_sorted_insert_queue_core.sv
// Arrival-sorted process queue, up to QUEUE_DEPTH descriptors held in one
// RAM used as a circular buffer. A request is taken when start is high and
// busy is low; each request yields exactly one result, shown for one cycle
// with out_valid high. The receiver cannot stall, so the result must be
// captured in that cycle. States walked from accepted request to the result:
//   insert into full or empty queue : S_INS
//   insert at head (key <= head key): S_INS, S_HEAD_CMP
//   insert elsewhere                : S_INS, S_HEAD_CMP, S_SCAN_CMP walk
//   pop, or pop of an empty queue   : S_POP, S_POP_DATA, or S_POP only
// The insert walk moves one entry per cycle through the single RAM port
// pair and the arrival-time comparators; busy falls in the cycle out_valid
// rises, so the next request may be taken alongside the result.
// out_status: 0 insert done, 1 pop done, 2 full (insert dropped), 3 empty
// pop. Popped fields are zero unless the status is pop done.
// out_entry_count is the fill level after the request (low 5 bits).
module arrival_sorted_insert_queue_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [15:0] in_process_id,
  input  logic [15:0] in_arrival_time,
  input  logic [15:0] in_burst_length,
  input  logic [7:0]  in_prio_level,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_process_id,
  output logic [15:0] out_arrival_time,
  output logic [15:0] out_burst_length,
  output logic [7:0]  out_prio_level,
  output logic [4:0]  out_entry_count
);

  localparam int CW = asiq_pkg::CNT_W;

  asiq_pkg::state_t   state_r, state_nxt;
  asiq_pkg::ctl_t     ctl;
  asiq_pkg::flags_t   flags;
  asiq_pkg::status_t  emit_status;
  asiq_pkg::entry_t   pop_entry;
  logic               emit, emit_data;
  logic [CW-1:0]      count_nxt;
  logic [CW+4:0]      count_ext;

  logic                           ram_wr_en;
  logic [asiq_pkg::IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
  logic [asiq_pkg::ENTRY_W-1:0]   ram_wr_data, ram_rd_data;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  asiq_pkg::entry_t   out_entry_r;
  logic [4:0]         out_count_r;

  asiq_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_process_id   (in_process_id),
    .in_arrival_time (in_arrival_time),
    .in_burst_length (in_burst_length),
    .in_prio_level   (in_prio_level),
    .flags           (flags),
    .count_nxt       (count_nxt),
    .ram_wr_en       (ram_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data)
  );

  asiq_ram #(
    .WIDTH (asiq_pkg::ENTRY_W),
    .DEPTH (asiq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign pop_entry = asiq_pkg::entry_t'(ram_rd_data);

  // ---------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      asiq_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (in_action == asiq_pkg::ACT_POP) ? asiq_pkg::S_POP : asiq_pkg::S_INS;
        end
      end
      asiq_pkg::S_INS: begin
        if (flags.full || flags.empty) begin
          state_nxt = asiq_pkg::S_IDLE;
        end else begin
          state_nxt = asiq_pkg::S_HEAD_CMP;
        end
      end
      asiq_pkg::S_HEAD_CMP: begin
        state_nxt = flags.arr_le_rd ? asiq_pkg::S_IDLE : asiq_pkg::S_SCAN_CMP;
      end
      asiq_pkg::S_SCAN_CMP: begin
        if (!flags.arr_lt_rd) begin
          state_nxt = asiq_pkg::S_IDLE;
        end
      end
      asiq_pkg::S_POP: begin
        state_nxt = flags.empty ? asiq_pkg::S_IDLE : asiq_pkg::S_POP_DATA;
      end
      asiq_pkg::S_POP_DATA: begin
        state_nxt = asiq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = asiq_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------
  always_comb begin
    ctl         = '0;
    ctl.rd_sel  = asiq_pkg::RD_HEAD;
    ctl.wr_sel  = asiq_pkg::WR_POS;
    emit        = 1'b0;
    emit_data   = 1'b0;
    emit_status = asiq_pkg::ST_INS_OK;
    case (state_r)
      asiq_pkg::S_IDLE: begin
        ctl.load = start;
      end
      asiq_pkg::S_INS: begin
        if (flags.full) begin
          emit        = 1'b1;
          emit_status = asiq_pkg::ST_FULL;
        end else if (flags.empty) begin
          // lone entry goes straight into the head slot
          ctl.wr_en   = 1'b1;
          ctl.wr_sel  = asiq_pkg::WR_HEAD;
          ctl.cnt_inc = 1'b1;
          emit        = 1'b1;
        end else begin
          ctl.rd_sel   = asiq_pkg::RD_HEAD;
          ctl.pos_init = 1'b1;
        end
      end
      asiq_pkg::S_HEAD_CMP: begin
        if (flags.arr_le_rd) begin
          // not later than head: new head, one slot back
          ctl.wr_en    = 1'b1;
          ctl.wr_sel   = asiq_pkg::WR_HEAD_M1;
          ctl.head_dec = 1'b1;
          ctl.cnt_inc  = 1'b1;
          emit         = 1'b1;
        end else begin
          ctl.rd_sel = asiq_pkg::RD_POS_M1;
        end
      end
      asiq_pkg::S_SCAN_CMP: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = asiq_pkg::WR_POS;
        if (flags.arr_lt_rd) begin
          // move the later entry up, read the next one down
          ctl.wr_shift = 1'b1;
          ctl.pos_dec  = 1'b1;
          ctl.rd_sel   = asiq_pkg::RD_POS_M1;
        end else begin
          ctl.cnt_inc = 1'b1;
          emit        = 1'b1;
        end
      end
      asiq_pkg::S_POP: begin
        if (flags.empty) begin
          emit        = 1'b1;
          emit_status = asiq_pkg::ST_EMPTY;
        end else begin
          ctl.rd_sel = asiq_pkg::RD_HEAD;
        end
      end
      asiq_pkg::S_POP_DATA: begin
        ctl.head_inc = 1'b1;
        ctl.cnt_dec  = 1'b1;
        emit         = 1'b1;
        emit_data    = 1'b1;
        emit_status  = asiq_pkg::ST_POP_OK;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= asiq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
    end
  end

  // result register: fill level is masked to the 5-bit port
  assign count_ext = {5'b0, count_nxt};

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= emit_status;
      out_entry_r  <= emit_data ? pop_entry : '0;
      out_count_r  <= count_ext[4:0];
    end
  end

  assign busy             = (state_r != asiq_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_process_id   = out_entry_r.process_id;
  assign out_arrival_time = out_entry_r.arr_time;
  assign out_burst_length = out_entry_r.burst_length;
  assign out_prio_level   = out_entry_r.prio_level;
  assign out_entry_count  = out_count_r;

endmodule

### tb/sv/tb_arrival_sorted_insert_queue_core.sv
`timescale 1ns / 1ps

module tb_arrival_sorted_insert_queue_core;
  import asiq_pkg::*;

  // Cycles with neither a request nor a result accepted before the run is
  // declared hung. The limit lies far above the worst insert walk and the
  // longest sender gap, so this leaves a wide margin.
  localparam int HANG_LIMIT = 2000;

  // Cycles allowed after the last expected reply, so that a stray extra
  // reply still has time to show up.
  localparam int TAIL_CYCLES = 30;

  // Slots in the ring of owed replies; at most two are ever pending.
  localparam int DUE_DEPTH = 8;

  // One reply as the queue should produce it.
  typedef struct packed {
    status_t     status;
    entry_t      popped;
    logic [4:0]  count;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [15:0] in_process_id;
  logic [15:0] in_arrival_time;
  logic [15:0] in_burst_length;
  logic [7:0]  in_prio_level;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_process_id;
  logic [15:0] out_arrival_time;
  logic [15:0] out_burst_length;
  logic [7:0]  out_prio_level;
  logic [4:0]  out_entry_count;

  // Mirror of the queue contents, kept in arrival order, head at index 0.
  entry_t held_entries [QUEUE_DEPTH];
  int     held_count;

  // Replies owed by the block, oldest first, as a ring with free-running
  // write and read counts.
  reply_t replies_due [DUE_DEPTH];
  int     due_wr = 0;
  int     due_rd = 0;

  int  mismatches;
  int  idle_run;
  bit  gaps_on;

  // Tallies of checked replies by expected status, for the end summary.
  int  n_inserted;
  int  n_popped;
  int  n_dropped_full;
  int  n_empty_pops;

  always #5 clk = ~clk;

  arrival_sorted_insert_queue_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_process_id    (in_process_id),
    .in_arrival_time  (in_arrival_time),
    .in_burst_length  (in_burst_length),
    .in_prio_level    (in_prio_level),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_process_id   (out_process_id),
    .out_arrival_time (out_arrival_time),
    .out_burst_length (out_burst_length),
    .out_prio_level   (out_prio_level),
    .out_entry_count  (out_entry_count)
  );

  // Applies one request to the mirror and returns the reply it earns.
  // Ordering rule: a key not later than the head's becomes the new head;
  // any other key goes after the last held entry with a key not later than
  // its own, so it trails equal keys already stored.
  function automatic reply_t sorted_queue_apply(logic act, entry_t item);
    reply_t r;
    int     pos;
    r.popped = '0;
    if (act == ACT_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        if (held_count == 0 || item.arr_time <= held_entries[0].arr_time) begin
          pos = 0;
        end else begin
          pos = held_count;
          while (pos > 0 && item.arr_time < held_entries[pos-1].arr_time)
            pos--;
        end
        for (int i = held_count; i > pos; i--)
          held_entries[i] = held_entries[i-1];
        held_entries[pos] = item;
        held_count++;
        r.status = ST_INS_OK;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped = held_entries[0];
        for (int i = 0; i < held_count - 1; i++)
          held_entries[i] = held_entries[i+1];
        held_count--;
        r.status = ST_POP_OK;
      end
    end
    r.count = 5'(held_count);
    return r;
  endfunction

  // Arrival keys: mostly a narrow band so ties are frequent, some at the
  // ends of the range, the rest spread over all 16 bits.
  function automatic logic [15:0] pick_arrival();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5)
      return 16'($urandom_range(0, 15));
    else if (sel < 7)
      return ($urandom_range(0, 1) != 0) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                         : 16'($urandom_range(0, 3));
    else
      return 16'($urandom);
  endfunction

  function automatic entry_t random_entry();
    entry_t e;
    e.process_id   = 16'($urandom);
    e.arr_time     = pick_arrival();
    e.burst_length = 16'($urandom);
    e.prio_level   = 8'($urandom);
    return e;
  endfunction

  function automatic entry_t make_entry(logic [15:0] id, logic [15:0] arr,
                                        logic [15:0] burst, logic [7:0] prio);
    entry_t e;
    e.process_id   = id;
    e.arr_time     = arr;
    e.burst_length = burst;
    e.prio_level   = prio;
    return e;
  endfunction

  // Gap before the next request: mostly none or short, now and then long.
  function automatic int pick_gap();
    int sel;
    if (!gaps_on)
      return 0;
    sel = $urandom_range(0, 99);
    if (sel < 65)      return 0;
    else if (sel < 92) return $urandom_range(1, 3);
    else               return $urandom_range(10, 40);
  endfunction

  // Sender idle for the given gap; the payload ports carry noise meanwhile.
  // Called at a rising edge; leaves off at a rising edge without having
  // scheduled anything for it.
  task automatic hold_off(int n);
    for (int i = 0; i < n; i++) begin
      if (i == 0)
        start <= 1'b0;
      in_action       <= 1'($urandom);
      in_process_id   <= 16'($urandom);
      in_arrival_time <= 16'($urandom);
      in_burst_length <= 16'($urandom);
      in_prio_level   <= 8'($urandom);
      @(posedge clk);
    end
  endtask

  // Presents one request, waits for the block to take it, records the reply
  // it owes, then idles for a random gap. start stays high when the gap is
  // zero so back-to-back requests follow without start dropping.
  task automatic send_request(logic act, entry_t item);
    start           <= 1'b1;
    in_action       <= act;
    in_process_id   <= item.process_id;
    in_arrival_time <= item.arr_time;
    in_burst_length <= item.burst_length;
    in_prio_level   <= item.prio_level;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    replies_due[due_wr % DUE_DEPTH] = sorted_queue_apply(act, item);
    due_wr++;
    hold_off(pick_gap());
  endtask

  // Sender stands back until every owed reply has come.
  task automatic wait_all_replies();
    start <= 1'b0;
    @(posedge clk);
    while (due_wr != due_rd)
      @(posedge clk);
  endtask

  task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    mismatches++;
  endtask

  // Reply checker: the receiver never stalls, so every cycle with out_valid
  // high is one reply, matched against the oldest owed one.
  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_valid) begin
      if (due_wr == due_rd) begin
        $display("%0t: reply with none owed, expected none actual status %0d",
                 $time, out_status);
        mismatches++;
      end else begin
        want = replies_due[due_rd % DUE_DEPTH];
        due_rd++;
        if (out_status !== want.status)
          report_mismatch("status", 16'(want.status), 16'(out_status));
        if (out_process_id !== want.popped.process_id)
          report_mismatch("process_id", want.popped.process_id, out_process_id);
        if (out_arrival_time !== want.popped.arr_time)
          report_mismatch("arrival", want.popped.arr_time, out_arrival_time);
        if (out_burst_length !== want.popped.burst_length)
          report_mismatch("burst_length", want.popped.burst_length, out_burst_length);
        if (out_prio_level !== want.popped.prio_level)
          report_mismatch("prio_level", 16'(want.popped.prio_level), 16'(out_prio_level));
        if (out_entry_count !== want.count)
          report_mismatch("entry_count", 16'(want.count), 16'(out_entry_count));
        case (want.status)
          ST_INS_OK: n_inserted++;
          ST_POP_OK: n_popped++;
          ST_FULL:   n_dropped_full++;
          default:   n_empty_pops++;
        endcase
      end
    end
  end

  // Hang guard: any accepted request or reply resets the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= HANG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d replies owed",
                 $time, HANG_LIMIT, due_wr - due_rd);
        $display("arrival_sorted_insert_queue_core regression: fail");
        $finish;
      end
    end
  end

  // Pop of an empty queue, one entry in and out, then empty again.
  task automatic test_empty_queue();
    send_request(ACT_POP, random_entry());
    send_request(ACT_INSERT, make_entry(16'h1234, 16'd100, 16'h00FF, 8'h5A));
    send_request(ACT_POP, random_entry());
    send_request(ACT_POP, random_entry());
    wait_all_replies();
  endtask

  // All-zero and all-one payloads; a zero key ties the zero head.
  task automatic test_field_extremes();
    send_request(ACT_INSERT, make_entry(16'h0000, 16'h0000, 16'h0000, 8'h00));
    send_request(ACT_INSERT, make_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_request(ACT_INSERT, make_entry(16'hA5A5, 16'h0000, 16'h5A5A, 8'hC3));
    repeat (3) send_request(ACT_POP, random_entry());
    wait_all_replies();
  endtask

  // Ties with the head go in front; ties further back go after their peers.
  task automatic test_arrival_ties();
    send_request(ACT_INSERT, make_entry(16'd1, 16'd50, 16'd10, 8'd1));
    send_request(ACT_INSERT, make_entry(16'd2, 16'd50, 16'd20, 8'd2));
    send_request(ACT_INSERT, make_entry(16'd3, 16'd60, 16'd30, 8'd3));
    send_request(ACT_INSERT, make_entry(16'd4, 16'd60, 16'd40, 8'd4));
    send_request(ACT_INSERT, make_entry(16'd5, 16'd55, 16'd50, 8'd5));
    send_request(ACT_INSERT, make_entry(16'd6, 16'd40, 16'd60, 8'd6));
    repeat (6) send_request(ACT_POP, random_entry());
    wait_all_replies();
  endtask

  // Free mix of inserts and pops, now and then waiting for every owed reply.
  task automatic test_random_mix(int n);
    for (int i = 0; i < n; i++) begin
      send_request(($urandom_range(0, 99) < 55) ? ACT_INSERT : ACT_POP, random_entry());
      if ($urandom_range(0, 59) == 0)
        wait_all_replies();
    end
    wait_all_replies();
  endtask

  // Insert bursts of 8 to 22 requests, which may overrun the queue, then pop
  // bursts that may empty it, each salted with a few of the other kind.
  task automatic test_fill_and_drain(int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(8, 22);
      for (int k = 0; k < burst; k++)
        send_request(($urandom_range(0, 9) == 0) ? ACT_POP : ACT_INSERT, random_entry());
      sent += burst;
      burst = $urandom_range(8, 22);
      for (int k = 0; k < burst; k++)
        send_request(($urandom_range(0, 9) == 0) ? ACT_INSERT : ACT_POP, random_entry());
      sent += burst;
    end
    wait_all_replies();
  endtask

  // Requests back to back with no sender gaps, so each one is taken in the
  // cycle its predecessor's reply appears.
  task automatic test_back_to_back(int n);
    gaps_on = 1'b0;
    test_fill_and_drain(n);
    gaps_on = 1'b1;
  endtask

  initial begin
    mismatches      = 0;
    held_count      = 0;
    gaps_on         = 1'b1;
    n_inserted      = 0;
    n_popped        = 0;
    n_dropped_full  = 0;
    n_empty_pops    = 0;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_action       <= ACT_INSERT;
    in_process_id   <= '0;
    in_arrival_time <= '0;
    in_burst_length <= '0;
    in_prio_level   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_field_extremes();
    test_arrival_ties();
    test_random_mix(550);
    test_fill_and_drain(500);
    test_back_to_back(260);

    // Let any stray reply surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d inserts, %0d pops, %0d inserts dropped on a full queue,",
             n_inserted, n_popped, n_dropped_full);
    $display("%0d pops of an empty queue, with head ties and back-to-back requests",
             n_empty_pops);
    if (mismatches == 0)
      $display("arrival_sorted_insert_queue_core regression: pass");
    else
      $display("arrival_sorted_insert_queue_core regression: fail");
    $finish;
  end

endmodule

### sim.f
design/asiq_pkg.sv
design/asiq_ram.sv
design/asiq_dpath.sv
design/arrival_sorted_insert_queue_core.sv
tb/sv/tb_arrival_sorted_insert_queue_core.sv
